FILE: hdl/c2rs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2rs_pkg
// shared field widths, constants and item types of the column-to-row span
// converter
// ----------------------------------------------------------------------------
package c2rs_pkg;

  localparam int unsigned COL_W       = 10;
  localparam int unsigned ROW_W       = 7;
  localparam int unsigned SPAN_ROW_W  = 6;

  localparam int unsigned ROWS_DEF    = 64;
  // screen width, only used to saturate the left end of a closed span
  localparam int unsigned COLUMNS     = 1024;

  typedef struct packed {
    logic [COL_W-1:0] column_x;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             first_column;
    logic             last_column;
  } in_item_t;

  typedef struct packed {
    logic [SPAN_ROW_W-1:0] span_row;
    logic [COL_W-1:0]      span_left;
    logic [COL_W-1:0]      span_right;
    logic                  span_final;
  } out_item_t;

endpackage

FILE: hdl/c2rs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2rs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module c2rs_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/column_to_row_span_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_to_row_span_converter
// turns column extents, fed right to left, into horizontal row spans
// ----------------------------------------------------------------------------
// a closed span passes the ram read register and the hold stage, and leaves the
//   output slot when another span follows it; the last span leaves from the
//   hold stage once the column walk is done; in_stall stays high until the
//   walk returns to idle, so a new column waits until the last one is done
// reset: control state and the previous extent clear to empty; the span-end
//   ram is not cleared and holds no meaning until a row is opened
module column_to_row_span_converter
  import c2rs_pkg::*;
#(
  parameter int unsigned ROWS = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned AW = $clog2(ROWS);
  localparam int unsigned XR_W = $clog2(COLUMNS) + 2;
  localparam logic [ROW_W-1:0] ROWS_V = ROW_W'(ROWS);
  localparam logic [XR_W-1:0] XR_MAX = XR_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLOSE_TOP, ST_CLOSE_BOT, ST_OPEN_TOP,
    ST_OPEN_BOT, ST_OPEN_FIRST, ST_FLUSH, ST_DRAIN
  } state_t;

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = (v > ROWS_V) ? ROWS_V : v;
    return r;
  endfunction

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] x_r, x_nxt, xr_r, xr_nxt;
  logic [ROW_W-1:0] t1_r, t1_nxt, b1_r, b1_nxt, t2_r, t2_nxt, b2_r, b2_nxt;
  logic [ROW_W-1:0] y_r, y_nxt;
  logic             last_r, last_nxt;
  logic [ROW_W-1:0] prev_top_r, prev_top_nxt, prev_bot_r, prev_bot_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [ROW_W-1:0] rd_row_r, rd_row_nxt;
  logic [COL_W-1:0] rd_left_r, rd_left_nxt;
  logic             hold_v_r, hold_v_nxt;
  out_item_t        hold_r, hold_nxt;
  logic             out_v_r, out_v_nxt;
  out_item_t        out_r, out_nxt;

  logic             mem_we, mem_re;
  logic [ROW_W-1:0] wr_row, rd_row;
  logic [COL_W-1:0] mem_rdata;
  logic             can_issue;
  logic [ROW_W-1:0] t1_c, b1_c;
  logic [XR_W-1:0]  xr_c;

  c2rs_ram #(
    .WIDTH (COL_W),
    .DEPTH (ROWS)
  ) u_span_end (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_row[AW-1:0]),
    .wr_data (x_r),
    .rd_en   (mem_re),
    .rd_addr (rd_row[AW-1:0]),
    .rd_data (mem_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // a span read may only start if the output slot is free when its data lands
  assign can_issue = !rd_v_r && (!out_v_r || !out_stall);

  assign t1_c = clamp_row(in_item.top_row);
  assign b1_c = clamp_row(in_item.bottom_row);
  assign xr_c = (XR_W'(in_item.column_x) + XR_W'(1) > XR_MAX) ? XR_MAX
              : XR_W'(in_item.column_x) + XR_W'(1);

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    xr_nxt       = xr_r;
    t1_nxt       = t1_r;
    b1_nxt       = b1_r;
    t2_nxt       = t2_r;
    b2_nxt       = b2_r;
    y_nxt        = y_r;
    last_nxt     = last_r;
    prev_top_nxt = prev_top_r;
    prev_bot_nxt = prev_bot_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_row       = y_r;
    rd_row       = t2_r;
    rd_left_nxt  = xr_r;

    // output slot and the one-span hold stage that decides span_final
    out_v_nxt  = out_v_r && out_stall;
    out_nxt    = out_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    if (rd_v_r) begin
      if (hold_v_r) begin
        out_nxt   = hold_r;
        out_v_nxt = 1'b1;
      end
      hold_nxt.span_row   = rd_row_r[SPAN_ROW_W-1:0];
      hold_nxt.span_left  = rd_left_r;
      hold_nxt.span_right = mem_rdata;
      hold_nxt.span_final = 1'b0;
      hold_v_nxt          = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt    = in_item.column_x;
          xr_nxt   = xr_c[COL_W-1:0];
          t1_nxt   = t1_c;
          b1_nxt   = b1_c;
          last_nxt = in_item.last_column;
          t2_nxt   = prev_top_r;
          b2_nxt   = prev_bot_r;
          prev_top_nxt = in_item.last_column ? '0 : t1_c;
          prev_bot_nxt = in_item.last_column ? '0 : b1_c;
          if (in_item.first_column) begin
            y_nxt     = t1_c;
            state_nxt = ST_OPEN_FIRST;
          end else begin
            state_nxt = ST_CLOSE_TOP;
          end
        end
      end
      ST_CLOSE_TOP: begin
        if (t2_r < ((t1_r < b2_r) ? t1_r : b2_r)) begin
          if (can_issue) begin
            mem_re = 1'b1;
            rd_row = t2_r;
            t2_nxt = t2_r + ROW_W'(1);
          end
        end else begin
          state_nxt = ST_CLOSE_BOT;
        end
      end
      ST_CLOSE_BOT: begin
        if (b2_r > ((b1_r > t2_r) ? b1_r : t2_r)) begin
          if (can_issue) begin
            mem_re = 1'b1;
            rd_row = b2_r - ROW_W'(1);
            b2_nxt = b2_r - ROW_W'(1);
          end
        end else begin
          y_nxt     = t1_r;
          state_nxt = ST_OPEN_TOP;
        end
      end
      ST_OPEN_TOP: begin
        if (y_r < ((t2_r < b1_r) ? t2_r : b1_r)) begin
          mem_we = 1'b1;
          wr_row = y_r;
          y_nxt  = y_r + ROW_W'(1);
        end else begin
          y_nxt     = b1_r;
          state_nxt = ST_OPEN_BOT;
        end
      end
      ST_OPEN_BOT: begin
        if (y_r > ((b2_r > t2_r) ? b2_r : t2_r)) begin
          mem_we = 1'b1;
          wr_row = y_r - ROW_W'(1);
          y_nxt  = y_r - ROW_W'(1);
        end else begin
          y_nxt     = b1_r;
          state_nxt = last_r ? ST_FLUSH : ST_DRAIN;
        end
      end
      ST_OPEN_FIRST: begin
        if (y_r < b1_r) begin
          mem_we = 1'b1;
          wr_row = y_r;
          y_nxt  = y_r + ROW_W'(1);
        end else begin
          y_nxt     = b1_r;
          state_nxt = last_r ? ST_FLUSH : ST_DRAIN;
        end
      end
      ST_FLUSH: begin
        // every open span closes at this column, bottom row first
        if (y_r > t1_r) begin
          if (can_issue) begin
            mem_re      = 1'b1;
            rd_row      = y_r - ROW_W'(1);
            rd_left_nxt = x_r;
            y_nxt       = y_r - ROW_W'(1);
          end
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r) begin
          if (!hold_v_r) begin
            state_nxt = ST_IDLE;
          end else if (!out_v_r || !out_stall) begin
            out_nxt            = hold_r;
            out_nxt.span_final = 1'b1;
            out_v_nxt          = 1'b1;
            hold_v_nxt         = 1'b0;
            state_nxt          = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_v_nxt   = mem_re;
    rd_row_nxt = rd_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prev_top_r <= '0;
      prev_bot_r <= '0;
      rd_v_r     <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prev_top_r <= prev_top_nxt;
      prev_bot_r <= prev_bot_nxt;
      rd_v_r     <= rd_v_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
    x_r       <= x_nxt;
    xr_r      <= xr_nxt;
    t1_r      <= t1_nxt;
    b1_r      <= b1_nxt;
    t2_r      <= t2_nxt;
    b2_r      <= b2_nxt;
    y_r       <= y_nxt;
    last_r    <= last_nxt;
    rd_row_r  <= rd_row_nxt;
    rd_left_r <= rd_left_nxt;
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
  end

  // a span landing from the ram must find the output slot free to shift into
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r && hold_v_r |-> !(out_v_r && out_stall))
    else $error("span data lost: output slot still full");

  // no span of an old column may linger once a new column can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !rd_v_r && !hold_v_r)
    else $error("idle with spans in flight");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_r))
    else $error("stalled item changed");

  // the ram is never read and written at once, span reads and span-end writes
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("ram read and write in one cycle");

endmodule
